// ----- hw/rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes of the i2c master byte controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // operation codes on the input channel
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // register index, taken from paddr bit 2
  localparam logic REG_SLAVE_ADDR  = 1'b0;
  localparam logic REG_HALF_PERIOD = 1'b1;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_WRITE,
    CMD_READ,
    CMD_STOP
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_RS_SDA_HIGH  = 4'd1,
    PH_RS_SCL_HIGH  = 4'd2,
    PH_ST_BOTH_HIGH = 4'd3,
    PH_ST_SDA_LOW   = 4'd4,
    PH_ST_SCL_LOW   = 4'd5,
    PH_BIT_LOW      = 4'd6,
    PH_BIT_HIGH     = 4'd7,
    PH_ACK_LOW      = 4'd8,
    PH_ACK_HIGH     = 4'd9,
    PH_FINISH       = 4'd10,
    PH_SP_LOW       = 4'd11,
    PH_SP_SCL_HIGH  = 4'd12,
    PH_SP_SDA_HIGH  = 4'd13
  } phase_t;

  // one classified tick waiting for the engine
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       dir;
    logic       nack;
    logic       sda_in;
  } tick_t;

  // one result transaction
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_en;
    logic       busy;
    logic       done;
    logic       acked;
    logic [7:0] rdata;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_master_byte_controller_top.sv -----
// ----------------------------------------------------------------------------
// i2c_master_byte_controller_top
// i2c master byte engine advanced, unless the output stalls, by one tick transaction per clock
// ----------------------------------------------------------------------------
// an accepted tick waits in the tick queue; its result is registered when the engine pops it
// throughput: one tick per cycle unless out_stall holds it; sequencer state updates only on a pop
// the tick queue (DEPTH entries) lets input keep flowing during an output stall until full
// reset: synchronous active-low; bus released (scl high, sda released), queue empty,
// half period back to 10, slave address 0
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_controller_top #(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // tick input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] in_operation,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_read_direction,
  input  wire logic       in_send_nack,
  input  wire logic       in_sda_in,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_sda_enable,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_slave_acked,
  output logic [7:0]      out_read_data,
  // register port
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [7:0]      slave_addr_r;
  logic [7:0]      half_period_r;
  logic            reg_wr;
  logic            q_valid;
  logic            q_pop;
  i2cm_pkg::tick_t q_tick;
  i2cm_pkg::res_t  res;

  // register file: the user must write it only while the engine sits idle; the block does not enforce this
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r  <= '0;
      half_period_r <= i2cm_pkg::HALF_PERIOD_RESET;
    end else if (reg_wr) begin
      unique case (paddr[2])
        i2cm_pkg::REG_SLAVE_ADDR:  slave_addr_r  <= pwdata[7:0];
        i2cm_pkg::REG_HALF_PERIOD: half_period_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      i2cm_pkg::REG_SLAVE_ADDR:  prdata = {24'd0, slave_addr_r};
      i2cm_pkg::REG_HALF_PERIOD: prdata = {24'd0, half_period_r};
      default:                   prdata = '0;
    endcase
  end

  // front: decode op codes and queue ticks
  i2cm_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .in_read_direction (in_read_direction),
    .in_send_nack      (in_send_nack),
    .in_sda_in         (in_sda_in),
    .q_valid           (q_valid),
    .q_tick            (q_tick),
    .q_pop             (q_pop)
  );

  // back: step sequencer and output register
  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_tick      (q_tick),
    .q_pop       (q_pop),
    .slave_addr  (slave_addr_r),
    .half_period (half_period_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_scl_level   = res.scl;
  assign out_sda_level   = res.sda;
  assign out_sda_enable  = res.sda_en;
  assign out_busy_res    = res.busy;
  assign out_done_res    = res.done;
  assign out_slave_acked = res.acked;
  assign out_read_data   = res.rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// i2cm_front
// decodes incoming ticks and holds them in a short queue for the engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [2:0]    in_operation,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_read_direction,
  input  wire logic          in_send_nack,
  input  wire logic          in_sda_in,
  output logic               q_valid,
  output i2cm_pkg::tick_t    q_tick,
  input  wire logic          q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  i2cm_pkg::tick_t       queue_r [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  push;
  logic                  pop;
  i2cm_pkg::cmd_t        cmd;
  i2cm_pkg::tick_t       tick_in;

  // unknown codes become no-ops
  always_comb begin
    unique case (in_operation)
      i2cm_pkg::OP_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::OP_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::OP_READ:  cmd = i2cm_pkg::CMD_READ;
      i2cm_pkg::OP_STOP:  cmd = i2cm_pkg::CMD_STOP;
      default:            cmd = i2cm_pkg::CMD_NONE;
    endcase
  end

  assign tick_in = '{cmd: cmd, data: in_data_byte, dir: in_read_direction,
                     nack: in_send_nack, sda_in: in_sda_in};

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_tick   = queue_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= tick_in;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// bus timing sequencer, advanced by one queued tick at a time, with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire i2cm_pkg::tick_t q_tick,
  output logic                 q_pop,
  input  wire logic [7:0]      slave_addr,
  input  wire logic [7:0]      half_period,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output i2cm_pkg::res_t       out_res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       sda_en_r, sda_en_nxt;
  logic       ack_r, ack_nxt;
  logic       held_r, held_nxt;
  logic       is_read_r, is_read_nxt;
  logic       nack_r, nack_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic       done_nxt;
  logic       out_valid_r;
  i2cm_pkg::res_t out_res_r;

  logic [7:0] hp;
  logic [7:0] tick_inc;
  logic       step_end;
  logic [7:0] shifted;
  logic [3:0] bit_dec;

  assign q_pop    = q_valid && (!out_valid_r || !out_stall);
  assign hp       = (half_period == 8'd0) ? 8'd1 : half_period;
  assign tick_inc = tick_r + 8'd1;
  assign step_end = (phase_r != i2cm_pkg::PH_IDLE) && (tick_inc >= hp);
  assign shifted  = {shift_r[6:0], is_read_r & q_tick.sda_in};
  assign bit_dec  = bit_cnt_r - 4'd1;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (phase_r == i2cm_pkg::PH_IDLE) begin
      unique case (q_tick.cmd)
        i2cm_pkg::CMD_START:
          phase_nxt = held_r ? i2cm_pkg::PH_RS_SDA_HIGH : i2cm_pkg::PH_ST_BOTH_HIGH;
        i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ:
          if (held_r) phase_nxt = i2cm_pkg::PH_BIT_LOW;
        i2cm_pkg::CMD_STOP:
          if (held_r) phase_nxt = i2cm_pkg::PH_SP_LOW;
        default: ;
      endcase
    end else if (step_end) begin
      unique case (phase_r)
        i2cm_pkg::PH_RS_SDA_HIGH:  phase_nxt = i2cm_pkg::PH_RS_SCL_HIGH;
        i2cm_pkg::PH_RS_SCL_HIGH,
        i2cm_pkg::PH_ST_BOTH_HIGH: phase_nxt = i2cm_pkg::PH_ST_SDA_LOW;
        i2cm_pkg::PH_ST_SDA_LOW:   phase_nxt = i2cm_pkg::PH_ST_SCL_LOW;
        i2cm_pkg::PH_ST_SCL_LOW:   phase_nxt = i2cm_pkg::PH_BIT_LOW;
        i2cm_pkg::PH_BIT_LOW:      phase_nxt = i2cm_pkg::PH_BIT_HIGH;
        i2cm_pkg::PH_BIT_HIGH:
          phase_nxt = (bit_dec != 4'd0) ? i2cm_pkg::PH_BIT_LOW : i2cm_pkg::PH_ACK_LOW;
        i2cm_pkg::PH_ACK_LOW:      phase_nxt = i2cm_pkg::PH_ACK_HIGH;
        i2cm_pkg::PH_ACK_HIGH:     phase_nxt = i2cm_pkg::PH_FINISH;
        i2cm_pkg::PH_SP_LOW:       phase_nxt = i2cm_pkg::PH_SP_SCL_HIGH;
        i2cm_pkg::PH_SP_SCL_HIGH:  phase_nxt = i2cm_pkg::PH_SP_SDA_HIGH;
        default:                   phase_nxt = i2cm_pkg::PH_IDLE;
      endcase
    end
  end

  // line drives and datapath
  always_comb begin
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    tick_nxt    = '0;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    sda_en_nxt  = sda_en_r;
    ack_nxt     = ack_r;
    held_nxt    = held_r;
    is_read_nxt = is_read_r;
    nack_nxt    = nack_r;
    rdata_nxt   = rdata_r;
    done_nxt    = 1'b0;
    if (phase_r == i2cm_pkg::PH_IDLE) begin
      unique case (q_tick.cmd)
        i2cm_pkg::CMD_START: begin
          shift_nxt  = {slave_addr[7:1], q_tick.dir};
          scl_nxt    = !held_r;
          sda_en_nxt = 1'b1;
          sda_nxt    = 1'b1;
        end
        i2cm_pkg::CMD_WRITE: begin
          if (!held_r) begin
            done_nxt = 1'b1;
          end else begin
            shift_nxt   = q_tick.data;
            is_read_nxt = 1'b0;
            bit_cnt_nxt = 4'd8;
            scl_nxt     = 1'b0;
            sda_en_nxt  = 1'b1;
            sda_nxt     = q_tick.data[7];
          end
        end
        i2cm_pkg::CMD_READ: begin
          if (!held_r) begin
            done_nxt = 1'b1;
          end else begin
            nack_nxt    = q_tick.nack;
            shift_nxt   = '0;
            is_read_nxt = 1'b1;
            bit_cnt_nxt = 4'd8;
            scl_nxt     = 1'b0;
            sda_en_nxt  = 1'b0;
            sda_nxt     = 1'b1;
          end
        end
        i2cm_pkg::CMD_STOP: begin
          if (!held_r) begin
            done_nxt = 1'b1;
          end else begin
            scl_nxt    = 1'b0;
            sda_en_nxt = 1'b1;
            sda_nxt    = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (!step_end) begin
      tick_nxt = tick_inc;
    end else begin
      unique case (phase_r)
        i2cm_pkg::PH_RS_SDA_HIGH: scl_nxt = 1'b1;
        i2cm_pkg::PH_RS_SCL_HIGH, i2cm_pkg::PH_ST_BOTH_HIGH: begin
          scl_nxt    = 1'b1;
          sda_en_nxt = 1'b1;
          sda_nxt    = 1'b0;
        end
        i2cm_pkg::PH_ST_SDA_LOW: scl_nxt = 1'b0;
        i2cm_pkg::PH_ST_SCL_LOW: begin
          // header goes out as a write byte
          held_nxt    = 1'b1;
          is_read_nxt = 1'b0;
          bit_cnt_nxt = 4'd8;
          scl_nxt     = 1'b0;
          sda_en_nxt  = 1'b1;
          sda_nxt     = shift_r[7];
        end
        i2cm_pkg::PH_BIT_LOW: scl_nxt = 1'b1;
        i2cm_pkg::PH_BIT_HIGH: begin
          shift_nxt   = shifted;
          bit_cnt_nxt = bit_dec;
          scl_nxt     = 1'b0;
          if (bit_dec != 4'd0) begin
            sda_en_nxt = !is_read_r;
            sda_nxt    = is_read_r | shifted[7];
          end else begin
            // ack slot: master drives low only for an acked read
            sda_en_nxt = is_read_r && !nack_r;
            sda_nxt    = !is_read_r || nack_r;
          end
        end
        i2cm_pkg::PH_ACK_LOW: scl_nxt = 1'b1;
        i2cm_pkg::PH_ACK_HIGH: begin
          if (is_read_r) begin
            rdata_nxt = shift_r;
          end else begin
            ack_nxt = !q_tick.sda_in;
          end
          scl_nxt    = 1'b0;
          sda_en_nxt = 1'b0;
          sda_nxt    = 1'b1;
        end
        i2cm_pkg::PH_FINISH: done_nxt = 1'b1;
        i2cm_pkg::PH_SP_LOW: scl_nxt = 1'b1;
        i2cm_pkg::PH_SP_SCL_HIGH: sda_nxt = 1'b1;
        i2cm_pkg::PH_SP_SDA_HIGH: begin
          scl_nxt    = 1'b1;
          sda_en_nxt = 1'b0;
          sda_nxt    = 1'b1;
          held_nxt   = 1'b0;
          done_nxt   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::PH_IDLE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      tick_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      sda_en_r    <= 1'b0;
      ack_r       <= 1'b0;
      held_r      <= 1'b0;
      is_read_r   <= 1'b0;
      nack_r      <= 1'b0;
      rdata_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        tick_r    <= tick_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        sda_en_r  <= sda_en_nxt;
        ack_r     <= ack_nxt;
        held_r    <= held_nxt;
        is_read_r <= is_read_nxt;
        nack_r    <= nack_nxt;
        rdata_r   <= rdata_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= '{scl: scl_nxt, sda: sda_nxt, sda_en: sda_en_nxt,
                     busy: (phase_nxt != i2cm_pkg::PH_IDLE), done: done_nxt,
                     acked: ack_nxt, rdata: rdata_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done |-> !out_res_r.busy)
    else $error("done reported while still busy");

  a_released_high: assert property (@(posedge clk) disable iff (!rst_n)
    !sda_en_r |-> sda_r)
    else $error("released sda not shown high");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter out of range");

  a_scl_high_phase: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cm_pkg::PH_BIT_HIGH || phase_r == i2cm_pkg::PH_ACK_HIGH |-> scl_r)
    else $error("scl low in a sampling step");

  a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cm_pkg::PH_IDLE |-> tick_r == 8'd0)
    else $error("step counter running while idle");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// i2c master byte controller testbench
// runs directed and random bus ticks through the engine; an internal model
// of the step sequencer predicts each result transaction that has no fixed
// answer, and every one is checked field by field as it leaves the block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int HALF_CLK = 2;

  // operation codes the engine must ignore
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

  // quiet idle bus straight after reset, without and with the done pulse
  localparam res_t BUS_FREE_QUIET = {1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
  localparam res_t BUS_FREE_DONE  = {1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00};

  // kinds of rows in the directed plan
  typedef enum logic [1:0] {
    ROW_TICK,  // a number of identical ticks
    ROW_CMD,   // one command tick, then empty ticks until the engine is idle
    ROW_CFG    // register write once everything in flight has come out
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] op;
    logic [7:0] data;
    logic       dir;
    logic       nack;
    logic       sda;
    logic [7:0] count;
    logic       typed;
    res_t       exp;
    logic       sel;
    logic [7:0] value;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = OP_NONE;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_read_direction = 1'b0;
  logic        in_send_nack = 1'b0;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_sda_enable;
  logic        out_busy_res;
  logic        out_done_res;
  logic        out_slave_acked;
  logic [7:0]  out_read_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // while set, neither side inserts gaps or stalls
  bit          calm = 1'b0;
  int unsigned errors = 0;

  // line states still owed by the block, oldest first
  res_t        bus_results_due[$];
  row_t        plan[$];

  // engine copy: register values and step sequencer state
  logic [7:0]  addr_byte = 8'h00;
  logic [7:0]  half_period = HALF_PERIOD_RESET;
  phase_t      eng_phase = PH_IDLE;
  logic [3:0]  bits_left = 4'd0;
  logic [7:0]  shifter = 8'h00;
  logic [7:0]  step_ticks = 8'h00;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        sda_oe_q = 1'b0;
  logic        ack_seen = 1'b0;
  logic        bus_owned = 1'b0;
  logic        reading = 1'b0;
  logic        nack_pick = 1'b0;
  logic [7:0]  last_read = 8'h00;

  // short periods and a tick budget per segment keep the random part small
  logic [7:0]  period_plan[6] = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd1, 8'd2};
  int unsigned tick_plan[6]   = '{40, 20, 15, 10, 15, 10};

  i2c_master_byte_controller_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .in_read_direction (in_read_direction),
    .in_send_nack      (in_send_nack),
    .in_sda_in         (in_sda_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_sda_enable    (out_sda_enable),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_slave_acked   (out_slave_acked),
    .out_read_data     (out_read_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #(HALF_CLK) clk = ~clk;

  // -------------------------------------------------------------------------
  // bus engine model
  // -------------------------------------------------------------------------

  function automatic void drive_lines(input logic scl, input logic oe, input logic sda);
    scl_q = scl;
    sda_oe_q = oe;
    sda_q = sda;
  endfunction

  // scl low with the next data bit, or sda released while reading
  function automatic void next_bit_low();
    eng_phase = PH_BIT_LOW;
    if (reading) begin
      drive_lines(1'b0, 1'b0, 1'b1);
    end else begin
      drive_lines(1'b0, 1'b1, shifter[7]);
    end
  endfunction

  function automatic void load_byte(input logic [7:0] value, input logic rd);
    shifter = value;
    reading = rd;
    bits_left = 4'd8;
    next_bit_low();
  endfunction

  // advance the engine by one tick and return the line state it leaves
  function automatic res_t predict_bus_tick(input logic [2:0] op, input logic [7:0] data,
                                            input logic dir, input logic nack,
                                            input logic sda_in);
    logic [7:0] period;
    logic       fin;
    res_t       r;
    // a zero half period still takes one tick per step
    period = (half_period == 8'd0) ? 8'd1 : half_period;
    fin = 1'b0;
    if (eng_phase == PH_IDLE) begin
      step_ticks = 8'd0;
      if (op == OP_START) begin
        shifter = {addr_byte[7:1], dir};
        // held bus means repeated start: first bring sda up under low scl
        if (bus_owned) begin
          eng_phase = PH_RS_SDA_HIGH;
          drive_lines(1'b0, 1'b1, 1'b1);
        end else begin
          eng_phase = PH_ST_BOTH_HIGH;
          drive_lines(1'b1, 1'b1, 1'b1);
        end
      end else if (op == OP_WRITE || op == OP_READ || op == OP_STOP) begin
        // nothing to do on a free bus, just signal completion
        if (!bus_owned) begin
          fin = 1'b1;
        end else if (op == OP_WRITE) begin
          load_byte(data, 1'b0);
        end else if (op == OP_READ) begin
          nack_pick = nack;
          load_byte(8'h00, 1'b1);
        end else begin
          eng_phase = PH_SP_LOW;
          drive_lines(1'b0, 1'b1, 1'b0);
        end
      end
    end else begin
      step_ticks = step_ticks + 8'd1;
      // a shortened period ends a running step at once
      if (step_ticks >= period) begin
        step_ticks = 8'd0;
        case (eng_phase)
          PH_RS_SDA_HIGH: begin
            eng_phase = PH_RS_SCL_HIGH;
            scl_q = 1'b1;
          end
          PH_RS_SCL_HIGH, PH_ST_BOTH_HIGH: begin
            eng_phase = PH_ST_SDA_LOW;
            drive_lines(1'b1, 1'b1, 1'b0);
          end
          PH_ST_SDA_LOW: begin
            eng_phase = PH_ST_SCL_LOW;
            scl_q = 1'b0;
          end
          PH_ST_SCL_LOW: begin
            bus_owned = 1'b1;
            load_byte(shifter, 1'b0);
          end
          PH_BIT_LOW: begin
            eng_phase = PH_BIT_HIGH;
            scl_q = 1'b1;
          end
          PH_BIT_HIGH: begin
            // sample at the end of the scl high step, msb first
            shifter = {shifter[6:0], reading & sda_in};
            bits_left = bits_left - 4'd1;
            if (bits_left != 4'd0) begin
              next_bit_low();
            end else begin
              eng_phase = PH_ACK_LOW;
              if (!reading || nack_pick) begin
                drive_lines(1'b0, 1'b0, 1'b1);
              end else begin
                drive_lines(1'b0, 1'b1, 1'b0);
              end
            end
          end
          PH_ACK_LOW: begin
            eng_phase = PH_ACK_HIGH;
            scl_q = 1'b1;
          end
          PH_ACK_HIGH: begin
            if (reading) begin
              last_read = shifter;
            end else begin
              ack_seen = ~sda_in;
            end
            eng_phase = PH_FINISH;
            drive_lines(1'b0, 1'b0, 1'b1);
          end
          PH_FINISH: begin
            eng_phase = PH_IDLE;
            fin = 1'b1;
          end
          PH_SP_LOW: begin
            eng_phase = PH_SP_SCL_HIGH;
            scl_q = 1'b1;
          end
          PH_SP_SCL_HIGH: begin
            eng_phase = PH_SP_SDA_HIGH;
            sda_q = 1'b1;
          end
          PH_SP_SDA_HIGH: begin
            drive_lines(1'b1, 1'b0, 1'b1);
            bus_owned = 1'b0;
            eng_phase = PH_IDLE;
            fin = 1'b1;
          end
          default: begin
            eng_phase = PH_IDLE;
          end
        endcase
      end
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.sda_en = sda_oe_q;
    r.busy = (eng_phase != PH_IDLE);
    r.done = fin;
    r.acked = ack_seen;
    r.rdata = last_read;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  // present one tick, wait until it is accepted and log what it must produce
  task automatic push_tick(input logic [2:0] op, input logic [7:0] data, input logic dir,
                           input logic nack, input logic sda, input logic typed,
                           input res_t exp);
    res_t r;
    // random gap before the tick, none during the calm stretch
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    in_read_direction <= dir;
    in_send_nack <= nack;
    in_sda_in <= sda;
    do @(posedge clk); while (in_stall);
    r = predict_bus_tick(op, data, dir, nack, sda);
    // directed rows with a fixed answer use it instead of the model
    bus_results_due.push_back(typed ? exp : r);
  endtask

  // register write on a quiet block: drain, settle, then setup and access
  task automatic write_reg(input logic sel, input logic [7:0] value);
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SLAVE_ADDR) begin
      addr_byte = value;
    end else begin
      half_period = value;
    end
  endtask

  task automatic add_tick(input logic [2:0] op, input logic [7:0] data, input logic sda,
                          input logic [7:0] count, input logic typed, input res_t exp);
    row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.op = op;
    row.data = data;
    row.sda = sda;
    row.count = count;
    row.typed = typed;
    row.exp = exp;
    plan.push_back(row);
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [7:0] data, input logic dir,
                         input logic nack, input logic sda);
    row_t row;
    row = '0;
    row.kind = ROW_CMD;
    row.op = op;
    row.data = data;
    row.dir = dir;
    row.nack = nack;
    row.sda = sda;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic sel, input logic [7:0] value);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.sel = sel;
    row.value = value;
    plan.push_back(row);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // result side: random stalls and per-field comparison
  // -------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_results_due.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        errors++;
      end else begin
        want = bus_results_due.pop_front();
        check_field("scl_level", want.scl, out_scl_level);
        check_field("sda_level", want.sda, out_sda_level);
        check_field("sda_enable", want.sda_en, out_sda_enable);
        check_field("busy_res", want.busy, out_busy_res);
        check_field("done_res", want.done, out_done_res);
        check_field("slave_acked", want.acked, out_slave_acked);
        check_field("read_data", want.rdata, out_read_data);
      end
    end
    out_stall <= rst_n && !calm && ($urandom_range(99) < 28);
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------

  initial begin : stimulus
    row_t        row;
    logic [2:0]  op;
    int unsigned roll;
    int unsigned issued;

    // directed plan; only the untouched bus right after reset has a typed answer
    add_tick(OP_NONE, 8'h00, 1'b1, 8'd2, 1'b1, BUS_FREE_QUIET);
    // write, read and stop on a free bus finish at once
    add_tick(OP_WRITE, 8'hA5, 1'b0, 8'd1, 1'b1, BUS_FREE_DONE);
    add_tick(OP_READ, 8'h00, 1'b1, 8'd1, 1'b1, BUS_FREE_DONE);
    add_tick(OP_STOP, 8'hFF, 1'b0, 8'd1, 1'b1, BUS_FREE_DONE);
    // undefined codes do nothing, not even a done pulse
    add_tick(OP_UNDEF_FIRST, 8'h00, 1'b1, 8'd1, 1'b1, BUS_FREE_QUIET);
    add_tick(OP_UNDEF_LAST, 8'hFF, 1'b0, 8'd1, 1'b1, BUS_FREE_QUIET);
    add_cfg(REG_SLAVE_ADDR, 8'hFF);
    // zero half period runs as one tick per step
    add_cfg(REG_HALF_PERIOD, 8'd0);
    add_cmd(OP_START, 8'h00, 1'b1, 1'b0, 1'b0);
    add_cmd(OP_WRITE, 8'h00, 1'b0, 1'b0, 1'b1);
    add_cmd(OP_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_READ, 8'h00, 1'b0, 1'b0, 1'b1);
    add_cmd(OP_READ, 8'hFF, 1'b0, 1'b1, 1'b0);
    // repeated start on the held bus
    add_cmd(OP_START, 8'h00, 1'b0, 1'b1, 1'b0);
    // a command arriving while busy is dropped
    add_tick(OP_WRITE, 8'h5A, 1'b0, 8'd1, 1'b0, '0);
    add_tick(OP_STOP, 8'h00, 1'b0, 8'd3, 1'b0, '0);
    add_cmd(OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
    add_cfg(REG_SLAVE_ADDR, 8'h00);
    // shrink the period partway through a step
    add_cfg(REG_HALF_PERIOD, 8'd20);
    add_tick(OP_START, 8'h00, 1'b0, 8'd1, 1'b0, '0);
    add_tick(OP_NONE, 8'h00, 1'b0, 8'd12, 1'b0, '0);
    add_cfg(REG_HALF_PERIOD, 8'd5);
    add_cmd(OP_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
    add_cmd(OP_STOP, 8'h00, 1'b0, 1'b0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < plan.size(); i++) begin
      row = plan[i];
      case (row.kind)
        ROW_CFG: begin
          write_reg(row.sel, row.value);
        end
        ROW_TICK: begin
          repeat (row.count) begin
            push_tick(row.op, row.data, row.dir, row.nack, row.sda, row.typed, row.exp);
          end
        end
        default: begin
          push_tick(row.op, row.data, row.dir, row.nack, row.sda, 1'b0, '0);
          while (eng_phase != PH_IDLE) begin
            push_tick(OP_NONE, row.data, row.dir, row.nack, row.sda, 1'b0, '0);
          end
        end
      endcase
    end

    // random part: mostly well-formed transfers, some commands on a free bus,
    // undefined codes and commands thrown at the busy engine
    for (int p = 0; p < $size(period_plan); p++) begin
      calm = (p == 0);
      if (p == 0) begin
        write_reg(REG_SLAVE_ADDR, 8'h00);
      end else if (p == 1) begin
        write_reg(REG_SLAVE_ADDR, 8'hFF);
      end else begin
        write_reg(REG_SLAVE_ADDR, 8'($urandom_range(255)));
      end
      write_reg(REG_HALF_PERIOD, period_plan[p]);
      issued = 0;
      while (issued < tick_plan[p]) begin
        if (eng_phase == PH_IDLE) begin
          roll = $urandom_range(99);
          if (!bus_owned) begin
            if (roll < 70) op = OP_START;
            else if (roll < 76) op = OP_WRITE;
            else if (roll < 82) op = OP_READ;
            else if (roll < 88) op = OP_STOP;
            else if (roll < 94) op = 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
            else op = OP_NONE;
          end else begin
            if (roll < 30) op = OP_WRITE;
            else if (roll < 55) op = OP_READ;
            else if (roll < 72) op = OP_STOP;
            else if (roll < 82) op = OP_START;
            else if (roll < 90) op = 3'($urandom_range(OP_UNDEF_LAST, OP_UNDEF_FIRST));
            else op = OP_NONE;
          end
        end else if ($urandom_range(99) < 12) begin
          op = 3'($urandom_range(OP_UNDEF_LAST));
        end else begin
          op = OP_NONE;
        end
        push_tick(op, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
        issued++;
      end
    end
    calm = 1'b0;

    // drain, then give the pipeline its latency before the verdict
    in_valid <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_master_byte_controller_top.sv
tb/testbench.sv
